FILE: rtl/rdc_pkg.sv
// Shared constants, types and the digit glyph function of the radix digit converter.
`default_nettype none

package rdc_pkg;

    localparam int RADIX_W        = 10;
    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 7;
    localparam int MAX_DIGITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 32;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP       = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 10'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 10'd1000;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 10'd10;
    localparam logic [RADIX_W-1:0] DEC_LIMIT   = 10'd10;
    localparam logic [RADIX_W-1:0] HEX_LIMIT   = 10'd16;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    // job classification carried through the queue next to the value
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               is_zero;
    } job_ctrl_t;

    // '0'..'9', 'A'..'F' for digits below sixteen, zero otherwise
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DEC_LIMIT)
        begin
            g = CHAR_ZERO + d[CHAR_W-1:0];
        end
        else if (d < HEX_LIMIT)
        begin
            g = CHAR_A + (d[CHAR_W-1:0] - DEC_LIMIT[CHAR_W-1:0]);
        end
        else
        begin
            g = '0;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rdc_front.sv
// Front end: radix register, input transfer, value masking, radix clamp and zero detect.
`default_nettype none

module rdc_front #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rdc_pkg::VALUE_W-1:0]   value,
    input  wire logic                          radix_wr_en,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   radix_wr_data,
    input  wire logic                          queue_full,
    output logic                               busy,
    output logic                               push,
    output logic [VALUE_BITS-1:0]              job_value,
    output rdc_pkg::job_ctrl_t                 job_ctrl
);

    logic [rdc_pkg::RADIX_W-1:0] radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rdc_pkg::RADIX_RESET;
        end
        else if (radix_wr_en)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    // keep the low VALUE_BITS bits, zero above the port width
    always_comb
    begin
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            job_value[i] = (i < rdc_pkg::VALUE_W) ? value[i % rdc_pkg::VALUE_W] : 1'b0;
        end
    end

    always_comb
    begin
        if (radix_reg < rdc_pkg::RADIX_MIN)
        begin
            job_ctrl.radix = rdc_pkg::RADIX_MIN;
        end
        else if (radix_reg > rdc_pkg::RADIX_MAX)
        begin
            job_ctrl.radix = rdc_pkg::RADIX_MAX;
        end
        else
        begin
            job_ctrl.radix = radix_reg;
        end
        job_ctrl.is_zero = (job_value == '0);
    end

    assign busy = queue_full;
    assign push = start && !queue_full;

endmodule

`default_nettype wire

FILE: rtl/rdc_queue.sv
// Two-entry job queue between front end and back end.
`default_nettype none

module rdc_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      head_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'(DEPTH));
    assign empty     = (count_reg == 2'd0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rdc_back.sv
// Back end: iterative radix divider, digit stack and most-significant-first emission.
`default_nettype none

module rdc_back #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire logic [VALUE_BITS-1:0]         q_value,
    input  wire rdc_pkg::job_ctrl_t            q_ctrl,
    output logic                               pop,
    output logic                               digit_strobe,
    output logic [rdc_pkg::RADIX_W-1:0]        digit_value,
    output logic [rdc_pkg::CHAR_W-1:0]         digit_char,
    output logic                               is_last
);

    localparam int ITER  = (VALUE_BITS + rdc_pkg::DIV_STEP - 1) / rdc_pkg::DIV_STEP;
    localparam int DIV_W = ITER * rdc_pkg::DIV_STEP;
    localparam int IW    = $clog2(ITER);
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int RW    = rdc_pkg::RADIX_W;

    rdc_pkg::back_state_t state_reg, state_next;

    logic [DIV_W-1:0] quo_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    base_reg;
    logic [IW-1:0]    iter_reg;
    logic [AW-1:0]    cnt_reg;
    logic [AW-1:0]    ptr_reg;
    logic [RW-1:0]    stack_mem [MAX_DIGITS];
    logic [RW-1:0]    rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_last_reg;

    logic [DIV_W-1:0] quo_w;
    logic [RW-1:0]    rem_w;
    logic [RW:0]      trial;
    logic             digit_done;

    // DIV_STEP restoring steps per cycle, quotient shifts in from the bottom
    always_comb
    begin
        rem_w = rem_reg;
        quo_w = quo_reg;
        trial = '0;
        for (int s = 0; s < rdc_pkg::DIV_STEP; s++)
        begin
            trial = {rem_w, quo_w[DIV_W-1]};
            quo_w = {quo_w[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, base_reg})
            begin
                trial    = trial - {1'b0, base_reg};
                quo_w[0] = 1'b1;
            end
            rem_w = trial[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        digit_done = 1'b0;
        unique case (state_reg)
            rdc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = q_ctrl.is_zero ? rdc_pkg::BK_EMIT : rdc_pkg::BK_DIV;
                end
            end
            rdc_pkg::BK_DIV:
            begin
                if (iter_reg == IW'(ITER - 1))
                begin
                    digit_done = 1'b1;
                    if (quo_w == '0 || cnt_reg == AW'(MAX_DIGITS - 1))
                    begin
                        state_next = rdc_pkg::BK_EMIT;
                    end
                end
            end
            rdc_pkg::BK_EMIT:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = rdc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rdc_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and digit stack
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            quo_reg  <= DIV_W'(q_value);
            rem_reg  <= '0;
            base_reg <= q_ctrl.radix;
        end
        else if (state_reg == rdc_pkg::BK_DIV)
        begin
            quo_reg <= quo_w;
            rem_reg <= digit_done ? '0 : rem_w;
        end

        if (pop && q_ctrl.is_zero)
        begin
            stack_mem[0] <= '0;
        end
        else if (digit_done)
        begin
            stack_mem[cnt_reg] <= rem_w;
        end

        if (state_reg == rdc_pkg::BK_EMIT)
        begin
            rd_data_reg <= stack_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg     <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                iter_reg <= '0;
                cnt_reg  <= '0;
                ptr_reg  <= '0;
            end
            else if (state_reg == rdc_pkg::BK_DIV)
            begin
                iter_reg <= digit_done ? '0 : iter_reg + IW'(1);
                if (digit_done)
                begin
                    if (state_next == rdc_pkg::BK_DIV)
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                    end
                    else
                    begin
                        ptr_reg <= cnt_reg;
                    end
                end
            end
            else if (state_reg == rdc_pkg::BK_EMIT && ptr_reg != '0)
            begin
                ptr_reg <= ptr_reg - AW'(1);
            end

            rd_valid_reg <= (state_reg == rdc_pkg::BK_EMIT);
            rd_last_reg  <= (state_reg == rdc_pkg::BK_EMIT) && (ptr_reg == '0);
        end
    end

    assign digit_strobe = rd_valid_reg;
    assign digit_value  = rd_data_reg;
    assign digit_char   = rdc_pkg::digit_glyph(rd_data_reg);
    assign is_last      = rd_valid_reg && rd_last_reg;

endmodule

`default_nettype wire

FILE: rtl/radix_digit_converter_core.sv
// Top level of the radix digit converter: front end, job queue and back end.
//
// Usage
//   Input: drive value and raise start; the transfer happens at a clock edge
//   where start is high and busy is low. busy rises only when the two-entry
//   job queue is full, so up to two values wait behind the one being worked.
//   Configuration: radix_wr_en writes radix_wr_data into the radix register
//   (reset 10). Write only while the block is idle. A radix below 2 acts as 2,
//   above 1000 acts as 1000; the radix is sampled when the value transfers.
//   Output: one digit per cycle, most significant first, each shown for one
//   cycle with digit_strobe high; is_last marks the least significant digit.
//   Zero gives the single digit 0. The receiver cannot stall the block.
// Divider
//   The divider resolves four quotient bits a cycle and runs once per digit,
//   least significant digit first, pushing each remainder onto the digit
//   stack. Digits of one value then come out back to back; while the divider
//   runs, no digit is shown. Zero skips the divider.
// Reset
//   rst_n clears the queue, the back-end sequencer and the output strobe, and
//   loads radix 10. The digit stack needs no clearing.

`default_nettype none

module radix_digit_converter_core #(
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rdc_pkg::VALUE_W-1:0]   value,
    input  wire logic                          radix_wr_en,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   radix_wr_data,
    output logic                               digit_strobe,
    output logic [rdc_pkg::RADIX_W-1:0]        digit_value,
    output logic [rdc_pkg::CHAR_W-1:0]         digit_char,
    output logic                               is_last
);

    // queue entry: value followed by its classification
    localparam int JOB_W = VALUE_BITS + $bits(rdc_pkg::job_ctrl_t);

    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;
    logic [VALUE_BITS-1:0]  job_value;
    rdc_pkg::job_ctrl_t     job_ctrl;
    logic [JOB_W-1:0]       head_data;
    logic [VALUE_BITS-1:0]  head_value;
    rdc_pkg::job_ctrl_t     head_ctrl;

    // front end: takes the transfer, masks the value, clamps the radix
    rdc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .value         (value),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .queue_full    (queue_full),
        .busy          (busy),
        .push          (push),
        .job_value     (job_value),
        .job_ctrl      (job_ctrl)
    );

    // decouples the input side from the long-running back end
    rdc_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({job_value, job_ctrl}),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head_data (head_data)
    );

    assign head_value = head_data[JOB_W-1 -: VALUE_BITS];
    assign head_ctrl  = rdc_pkg::job_ctrl_t'(head_data[$bits(rdc_pkg::job_ctrl_t)-1:0]);

    // back end: digit extraction least significant first, then emission in reverse
    rdc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (queue_empty),
        .q_value      (head_value),
        .q_ctrl       (head_ctrl),
        .pop          (pop),
        .digit_strobe (digit_strobe),
        .digit_value  (digit_value),
        .digit_char   (digit_char),
        .is_last      (is_last)
    );

endmodule

`default_nettype wire

FILE: rtl/rdc_checker.sv
// Port-level checks of the radix digit converter and their binding to the top level.
`default_nettype none

module rdc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          digit_strobe,
    input wire logic [rdc_pkg::RADIX_W-1:0]   digit_value,
    input wire logic [rdc_pkg::CHAR_W-1:0]    digit_char,
    input wire logic                          is_last
);

    // the last-digit mark only appears on a strobed digit
    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        is_last |-> digit_strobe)
        else $error("is_last without digit_strobe");

    // no digit reaches the largest radix
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_strobe |-> (digit_value < rdc_pkg::RADIX_MAX))
        else $error("digit out of range");

    a_glyph_small: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_strobe && digit_value < rdc_pkg::HEX_LIMIT) |-> (digit_char != '0))
        else $error("missing glyph for small digit");

    a_glyph_large: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_strobe && digit_value >= rdc_pkg::HEX_LIMIT) |-> (digit_char == '0))
        else $error("glyph on large digit");

    // digits of one value come out in consecutive cycles
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_strobe && !is_last) |=> digit_strobe)
        else $error("gap inside a digit burst");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .digit_strobe (digit_strobe),
    .digit_value  (digit_value),
    .digit_char   (digit_char),
    .is_last      (is_last)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for radix_digit_converter_core: directed and random values over many radixes.
`timescale 1ns / 1ps

module tb_top;

    // Expected digits of the values transferred so far, not yet seen, oldest first.
    class digit_scoreboard;

        typedef struct packed {
            logic [rdc_pkg::RADIX_W-1:0] value;
            logic [rdc_pkg::CHAR_W-1:0]  glyph;
            logic                        last;
        } digit_t;

        digit_t pending_digits[$];
        int     mismatches = 0;

        // Radix as the block uses it: clipped into 2..1000.
        static function logic [rdc_pkg::RADIX_W-1:0] clip_radix(logic [rdc_pkg::RADIX_W-1:0] raw);
            if (raw < rdc_pkg::RADIX_MIN)
            begin
                return rdc_pkg::RADIX_MIN;
            end
            if (raw > rdc_pkg::RADIX_MAX)
            begin
                return rdc_pkg::RADIX_MAX;
            end
            return raw;
        endfunction

        // Split the value into digits, least significant first, then queue them
        // most significant first; only the low MAX_DIGITS digits survive.
        function void expect_digits_of(logic [rdc_pkg::VALUE_W-1:0] val,
                                       logic [rdc_pkg::RADIX_W-1:0] raw);
            logic [63:0]                 rest;
            logic [63:0]                 base;
            logic [rdc_pkg::RADIX_W-1:0] stack [rdc_pkg::MAX_DIGITS_DEF];
            int                          count;
            digit_t                      d;
            string                       glyphs;
            byte                         ch;
            glyphs = "0123456789ABCDEF";
            base   = 64'(clip_radix(raw));
            rest   = 64'(val);
            count  = 0;
            do
            begin
                stack[count] = rdc_pkg::RADIX_W'(rest % base);
                rest         = rest / base;
                count++;
            end while (rest != 0 && count < rdc_pkg::MAX_DIGITS_DEF);
            for (int k = count - 1; k >= 0; k--)
            begin
                d.value = stack[k];
                if (stack[k] < rdc_pkg::HEX_LIMIT)
                begin
                    ch      = glyphs.getc(int'(stack[k]));
                    d.glyph = ch[rdc_pkg::CHAR_W-1:0];
                end
                else
                begin
                    d.glyph = '0;
                end
                d.last = (k == 0);
                pending_digits.push_back(d);
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_digit(logic [rdc_pkg::RADIX_W-1:0] dv, logic [rdc_pkg::CHAR_W-1:0] gl,
                         logic last);
            digit_t want;
            if (pending_digits.size() == 0)
            begin
                report($sformatf("unexpected digit %0d (char %h, last %b)", dv, gl, last));
            end
            else
            begin
                want = pending_digits.pop_front();
                if (dv !== want.value)
                begin
                    report($sformatf("digit_value %0d, want %0d", dv, want.value));
                end
                if (gl !== want.glyph)
                begin
                    report($sformatf("digit_char %h, want %h (digit %0d)", gl, want.glyph,
                                     want.value));
                end
                if (last !== want.last)
                begin
                    report($sformatf("is_last %b, want %b (digit %0d)", last, want.last,
                                     want.value));
                end
            end
        endtask

    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [rdc_pkg::VALUE_W-1:0] value;
    logic                        radix_wr_en;
    logic [rdc_pkg::RADIX_W-1:0] radix_wr_data;
    logic                        digit_strobe;
    logic [rdc_pkg::RADIX_W-1:0] digit_value;
    logic [rdc_pkg::CHAR_W-1:0]  digit_char;
    logic                        is_last;

    digit_scoreboard             sb;
    // our copy of the radix register, as last written
    logic [rdc_pkg::RADIX_W-1:0] radix_reg;

    radix_digit_converter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .digit_strobe  (digit_strobe),
        .digit_value   (digit_value),
        .digit_char    (digit_char),
        .is_last       (is_last)
    );

    always #5 clk = ~clk;

    // Hard stop: the slowest legal run (radix 2, all 32 digits, every item) is
    // under a fifth of this.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Digits are shown for one cycle only; take each one at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && digit_strobe)
        begin
            sb.check_digit(digit_value, digit_char, is_last);
        end
    end

    // Called and returns at a falling edge. A random gap with start low comes
    // first; with no gap start stays high from the previous transfer, so
    // back-to-back items fill the job queue and push busy up.
    task send_value(logic [rdc_pkg::VALUE_W-1:0] v);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end while (busy);
        // transfer taken at this edge; the radix is sampled with it
        sb.expect_digits_of(v, radix_reg);
        @(negedge clk);
    endtask

    // Drop start and let every queued digit come out before touching the radix.
    task wait_idle();
        start <= 1'b0;
        while (sb.pending_digits.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task write_radix(logic [rdc_pkg::RADIX_W-1:0] raw);
        wait_idle();
        radix_wr_en   <= 1'b1;
        radix_wr_data <= raw;
        @(negedge clk);
        radix_wr_en   <= 1'b0;
        radix_reg      = raw;
    endtask

    // Random value shaped by the radix: full width, short values, powers of
    // the radix and their neighbours (digit count steps), zero, near all-ones.
    function logic [rdc_pkg::VALUE_W-1:0] pick_value(logic [rdc_pkg::RADIX_W-1:0] raw);
        logic [63:0] p;
        logic [63:0] b;
        int          k;
        b = 64'(digit_scoreboard::clip_radix(raw));
        case ($urandom_range(0, 6))
            0, 1:
            begin
                return $urandom;
            end
            2:
            begin
                return $urandom_range(0, int'(b * b));
            end
            3:
            begin
                p = 64'd1;
                k = $urandom_range(1, 32);
                repeat (k) if (p * b <= 64'hFFFF_FFFF) p = p * b;
                return p[rdc_pkg::VALUE_W-1:0] - rdc_pkg::VALUE_W'($urandom_range(0, 1));
            end
            4:
            begin
                return '0;
            end
            5:
            begin
                return 32'hFFFF_FFFF - rdc_pkg::VALUE_W'($urandom_range(0, int'(b)));
            end
            default:
            begin
                return $urandom >> $urandom_range(0, 31);
            end
        endcase
    endfunction

    initial
    begin
        logic [rdc_pkg::RADIX_W-1:0] phase_radix [10];
        sb            = new;
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        value         = '0;
        radix_wr_en   = 1'b0;
        radix_wr_data = '0;
        radix_reg     = rdc_pkg::RADIX_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset radix (decimal): zero, single digit, first carry, extremes.
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd1_000_000_000);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);

        // Hex: every letter glyph, and the fifteen/sixteen boundary.
        write_radix(10'd16);
        send_value(32'hFEDC_BA98);
        send_value(32'hDEAD_BEEF);
        send_value(32'd15);
        send_value(32'd16);

        // Binary: the longest digit string the block can produce.
        write_radix(10'd2);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1);

        // Largest radix: digits well above the glyph range.
        write_radix(10'd1000);
        send_value(32'd999);
        send_value(32'd1000);
        send_value(32'hFFFF_FFFF);

        // Radix below two acts as two; above a thousand acts as a thousand.
        write_radix(10'd0);
        send_value(32'd5);
        write_radix(10'd1023);
        send_value(32'd123_456_789);

        // Base 36: digit 15 is 'F', digit 16 and up has no character.
        write_radix(10'd36);
        send_value(32'd15);
        send_value(32'd16);
        send_value(32'd35);

        // Random part: ten phases of 25 transfers, extremes of the register first.
        phase_radix = '{10'd2, 10'd1000, 10'd1, 10'd1023, 10'd10, 10'd16, 10'd1001,
                        10'd0, 10'd0, 10'd0};
        phase_radix[8] = rdc_pkg::RADIX_W'($urandom_range(3, 40));
        phase_radix[9] = rdc_pkg::RADIX_W'($urandom_range(0, 1023));
        for (int ph = 0; ph < 10; ph++)
        begin
            write_radix(phase_radix[ph]);
            repeat (25) send_value(pick_value(phase_radix[ph]));
        end

        // Drain, then give the block time to show any stray digit.
        wait_idle();
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
